/* hw/rtl/tmqt_pkg.sv */
// shared types, sizes and codes of the typed message queue table
package tmqt_pkg;

    localparam int NUM_QUEUES          = 16;
    localparam int POOL_ENTRIES        = 64;
    localparam int MAX_MESSAGE_BYTES   = 8192;
    localparam int DEFAULT_QUEUE_BYTES = 16384;

    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int EW  = $clog2(POOL_ENTRIES);
    localparam int CW  = $clog2(POOL_ENTRIES + 1);
    // descriptor word: type, size, payload reference
    localparam int DW  = 31 + 14 + 32;

    localparam logic [8:0] MODE_MASK = 9'o777;

    typedef enum logic [2:0] {
        OP_GET     = 3'd0,
        OP_SEND    = 3'd1,
        OP_RECEIVE = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_STAT    = 3'd4,
        OP_SET     = 3'd5,
        OP_INFO    = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_INVALID   = 4'd1,
        ST_EXISTS    = 4'd2,
        ST_NOT_FOUND = 4'd3,
        ST_NO_SPACE  = 4'd4,
        ST_FULL      = 4'd5,
        ST_POOL      = 4'd6,
        ST_NO_MSG    = 4'd7,
        ST_TOO_BIG   = 4'd8
    } t_status;

endpackage

/* hw/rtl/typed_message_queue_table_core.sv */
// typed message queue table: slot table, descriptor pool and operation sequencer
//
// channel  | direction | handshake           | payload
// command  | in        | i_start, o_busy     | i_operation .. i_copy_flag
// result   | out       | o_done (one cycle)  | o_status .. o_mode_out
//
// one item at a time; o_busy is high from acceptance until the result strobe.
// get with a key scans the slots, one slot a cycle, and the private key skips the
// scan; receive walks the descriptor chain, one descriptor a cycle, and remove
// returns each descriptor to the free list in turn; stat, set, info and early
// errors finish at dispatch. the descriptor memories give one read a cycle.
// synchronous active-low reset empties the table; the next-link store reads
// as one free chain through valid bits, so no clearing pass is needed.
// o_done is high for one cycle, the fields hold to the next result; no receiver stall.
module typed_message_queue_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_queue_id,
    input  logic [31:0] i_key,
    input  logic signed [31:0] i_msg_type,
    input  logic [15:0] i_length,
    input  logic [31:0] i_payload_ref,
    input  logic [8:0]  i_mode_bits,
    input  logic        i_create_flag,
    input  logic        i_exclusive_flag,
    input  logic        i_no_error_flag,
    input  logic        i_copy_flag,
    output logic        o_done,
    output logic [3:0]  o_status,
    output logic [3:0]  o_queue_id_out,
    output logic [30:0] o_msg_type_out,
    output logic [13:0] o_length_out,
    output logic [31:0] o_payload_ref_out,
    output logic [14:0] o_queued_bytes,
    output logic [6:0]  o_queued_count,
    output logic [14:0] o_byte_limit,
    output logic [8:0]  o_mode_out
);
    localparam int NQ = tmqt_pkg::NUM_QUEUES;
    localparam int NP = tmqt_pkg::POOL_ENTRIES;
    localparam int QIW = tmqt_pkg::QIW;
    localparam int EW = tmqt_pkg::EW;
    localparam int CW = tmqt_pkg::CW;
    localparam int DW = tmqt_pkg::DW;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DISP  = 13'b0000000000010,
        S_GSCAN = 13'b0000000000100,
        S_GFIN  = 13'b0000000001000,
        S_SRD   = 13'b0000000010000,
        S_SLINK = 13'b0000000100000,
        S_RWALK = 13'b0000001000000,
        S_RFIN  = 13'b0000010000000,
        S_RUNL  = 13'b0000100000000,
        S_RFREE = 13'b0001000000000,
        S_MWALK = 13'b0010000000000,
        S_MFIN  = 13'b0100000000000,
        S_SPARE = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // latched item
    tmqt_pkg::t_op r_op, n_op;
    logic [3:0]  r_q, n_q;
    logic [31:0] r_key, n_key;
    logic [31:0] r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [31:0] r_ref, n_ref;
    logic [8:0]  r_mode, n_mode;
    logic r_cr, n_cr, r_ex, n_ex, r_ne, n_ne, r_cp, n_cp;

    // walk and scan state
    logic [QIW-1:0] r_i, n_i, r_gidx, n_gidx;
    logic r_gfound, n_gfound;
    logic [EW-1:0] r_cur, n_cur, r_prevw, n_prevw;
    logic [CW-1:0] r_pos, n_pos, r_fpos, n_fpos;
    logic r_found, n_found;
    logic [EW-1:0] r_f, n_f, r_fprev, n_fprev, r_fnext, n_fnext;
    logic [30:0] r_ftype, n_ftype;
    logic [13:0] r_fsize, n_fsize;
    logic [31:0] r_fref, n_fref;

    // free list
    logic [EW-1:0] r_fhead, n_fhead;
    logic [CW-1:0] r_fcnt, n_fcnt;

    // slot table
    logic [NQ-1:0] r_use;
    logic [31:0] r_skey   [NQ];
    logic [8:0]  r_smode  [NQ];
    logic [14:0] r_sbytes [NQ];
    logic [6:0]  r_scount [NQ];
    logic [14:0] r_slimit [NQ];
    logic [EW-1:0] r_shead [NQ];
    logic [EW-1:0] r_stail [NQ];

    // result
    logic        r_done;
    logic [3:0]  r_status, r_qo;
    logic [30:0] r_otype;
    logic [13:0] r_olen;
    logic [31:0] r_oref;
    logic [14:0] r_obytes, r_olimit;
    logic [6:0]  r_ocount;
    logic [8:0]  r_omode;

    // memory ports
    logic [EW-1:0] rd_addr;
    logic          d_we, x_we;
    logic [EW-1:0] d_waddr, x_waddr, x_wdata;
    logic [DW-1:0] d_wdata, d_rdata;
    logic [EW-1:0] x_rdata;
    logic [NP-1:0] r_nval;
    logic          r_nrv;
    logic [EW-1:0] r_nra, nx;

    // slot update strobes
    logic up_create, up_set, up_push, up_recv, up_clear;

    // finish
    logic fin;
    tmqt_pkg::t_status fst;
    logic [3:0] fqo;
    logic fstat, frecv;

    logic [QIW-1:0] qi, ffree;
    logic q_ok, any_free;
    logic [13:0] dlv;
    logic [30:0] t_cur;
    logic [32:0] mag;
    logic hit0, hitm, sel_pos;

    tmqt_ram #(.W(DW), .D(NP)) u_desc (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(rd_addr), .o_rdata(d_rdata)
    );

    tmqt_ram #(.W(EW), .D(NP)) u_next (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_waddr), .i_wdata(x_wdata),
        .i_raddr(rd_addr), .o_rdata(x_rdata)
    );

    // next link with never-written entries reading as the free chain
    assign nx = r_nrv ? x_rdata :
                ((32'(r_nra) == NP - 1) ? '0 : EW'(32'(r_nra) + 1));

    assign qi   = r_q[QIW-1:0];
    assign q_ok = (32'(r_q) < NQ) && r_use[qi];

    // first free slot
    always_comb begin
        ffree = '0;
        any_free = 1'b0;
        for (int k = NQ - 1; k >= 0; k--) begin
            if (!r_use[k]) begin
                ffree = QIW'(k);
                any_free = 1'b1;
            end
        end
    end

    // receive selector compare
    assign t_cur   = d_rdata[DW-1:46];
    assign mag     = 33'd0 - {r_type[31], r_type};
    assign sel_pos = !r_type[31] && (r_type != 32'd0);
    assign hit0    = (r_type == 32'd0) || (sel_pos && ({1'b0, t_cur} == r_type));
    assign hitm    = r_type[31] && ({2'b00, t_cur} <= mag) && (!r_found || (t_cur < r_ftype));
    assign dlv     = (32'(r_fsize) > 32'(r_len)) ? r_len[13:0] : r_fsize;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_op = r_op; n_q = r_q; n_key = r_key; n_type = r_type; n_len = r_len;
        n_ref = r_ref; n_mode = r_mode; n_cr = r_cr; n_ex = r_ex; n_ne = r_ne; n_cp = r_cp;
        n_i = r_i; n_gidx = r_gidx; n_gfound = r_gfound;
        n_cur = r_cur; n_prevw = r_prevw; n_pos = r_pos; n_found = r_found;
        n_f = r_f; n_fprev = r_fprev; n_fpos = r_fpos; n_fnext = r_fnext;
        n_ftype = r_ftype; n_fsize = r_fsize; n_fref = r_fref;
        n_fhead = r_fhead; n_fcnt = r_fcnt;
        rd_addr = r_cur;
        d_we = 1'b0; d_waddr = r_fhead; d_wdata = {r_type[30:0], r_len[13:0], r_ref};
        x_we = 1'b0; x_waddr = r_cur; x_wdata = '0;
        up_create = 1'b0; up_set = 1'b0; up_push = 1'b0; up_recv = 1'b0; up_clear = 1'b0;
        fin = 1'b0; fst = tmqt_pkg::ST_OK; fqo = '0; fstat = 1'b0; frecv = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = tmqt_pkg::t_op'(i_operation);
                    n_q = i_queue_id; n_key = i_key; n_type = i_msg_type;
                    n_len = i_length; n_ref = i_payload_ref; n_mode = i_mode_bits;
                    n_cr = i_create_flag; n_ex = i_exclusive_flag;
                    n_ne = i_no_error_flag; n_cp = i_copy_flag;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_op)
                    tmqt_pkg::OP_GET: begin
                        n_gfound = 1'b0;
                        n_i = '0;
                        n_state = (r_key != 32'd0) ? S_GSCAN : S_GFIN;
                    end
                    tmqt_pkg::OP_SEND: begin
                        if (!q_ok || r_len > 16'(tmqt_pkg::MAX_MESSAGE_BYTES) ||
                            r_type[31] || r_type == 32'd0) begin
                            fin = 1'b1; fst = tmqt_pkg::ST_INVALID;
                        end else if ((17'(r_sbytes[qi]) + 17'(r_len)) > 17'(r_slimit[qi])) begin
                            fin = 1'b1; fst = tmqt_pkg::ST_FULL;
                        end else if (r_fcnt == '0) begin
                            fin = 1'b1; fst = tmqt_pkg::ST_POOL;
                        end else begin
                            rd_addr = r_fhead;
                            n_state = S_SRD;
                        end
                    end
                    tmqt_pkg::OP_RECEIVE: begin
                        if (!q_ok) begin
                            fin = 1'b1; fst = tmqt_pkg::ST_INVALID;
                        end else if (r_scount[qi] == 7'd0) begin
                            fin = 1'b1; fst = tmqt_pkg::ST_NO_MSG;
                        end else begin
                            rd_addr = r_shead[qi];
                            n_cur = r_shead[qi]; n_pos = '0; n_found = 1'b0; n_prevw = '0;
                            n_state = S_RWALK;
                        end
                    end
                    tmqt_pkg::OP_REMOVE: begin
                        if (!q_ok) begin
                            fin = 1'b1; fst = tmqt_pkg::ST_INVALID;
                        end else if (r_scount[qi] == 7'd0) begin
                            n_state = S_MFIN;
                        end else begin
                            rd_addr = r_shead[qi];
                            n_cur = r_shead[qi]; n_pos = '0;
                            n_state = S_MWALK;
                        end
                    end
                    tmqt_pkg::OP_STAT: begin
                        fin = 1'b1;
                        fst = q_ok ? tmqt_pkg::ST_OK : tmqt_pkg::ST_INVALID;
                        fstat = 1'b1;
                    end
                    tmqt_pkg::OP_SET: begin
                        fin = 1'b1;
                        fst = q_ok ? tmqt_pkg::ST_OK : tmqt_pkg::ST_INVALID;
                        up_set = q_ok;
                    end
                    tmqt_pkg::OP_INFO: begin
                        fin = 1'b1;
                        fqo = 4'(NQ - 1);
                    end
                    default: begin
                        fin = 1'b1; fst = tmqt_pkg::ST_INVALID;
                    end
                endcase
            end
            // key scan, one slot a cycle
            S_GSCAN: begin
                if (r_use[r_i] && r_skey[r_i] == r_key && !r_gfound) begin
                    n_gfound = 1'b1;
                    n_gidx = r_i;
                end
                if (32'(r_i) == NQ - 1) begin
                    n_state = S_GFIN;
                end else begin
                    n_i = QIW'(32'(r_i) + 1);
                end
            end
            S_GFIN: begin
                fin = 1'b1;
                if (r_gfound) begin
                    if (r_cr && r_ex) begin
                        fst = tmqt_pkg::ST_EXISTS;
                    end else begin
                        fqo = 4'(r_gidx);
                    end
                end else if (r_key != 32'd0 && !r_cr) begin
                    fst = tmqt_pkg::ST_NOT_FOUND;
                end else if (!any_free) begin
                    fst = tmqt_pkg::ST_NO_SPACE;
                end else begin
                    up_create = 1'b1;
                    fqo = 4'(ffree);
                end
            end
            // send: take the free head, append to the chain
            S_SRD: begin
                d_we = 1'b1;
                x_we = 1'b1; x_waddr = r_fhead; x_wdata = '0;
                n_fhead = nx;
                n_fcnt = r_fcnt - 1'b1;
                n_cur = r_fhead;
                n_prevw = r_stail[qi];
                up_push = 1'b1;
                if (r_scount[qi] == 7'd0) begin
                    fin = 1'b1;
                end else begin
                    n_state = S_SLINK;
                end
            end
            S_SLINK: begin
                x_we = 1'b1; x_waddr = r_prevw; x_wdata = r_cur;
                fin = 1'b1;
            end
            // typed receive walk, one descriptor a cycle
            S_RWALK: begin
                if (hit0 || hitm) begin
                    n_found = 1'b1; n_f = r_cur; n_fprev = r_prevw; n_fpos = r_pos;
                    n_ftype = t_cur; n_fsize = d_rdata[45:32]; n_fref = d_rdata[31:0];
                    n_fnext = nx;
                end
                if (hit0 || 7'(r_pos + 1'b1) == r_scount[qi]) begin
                    n_state = S_RFIN;
                end else begin
                    n_prevw = r_cur;
                    n_cur = nx;
                    rd_addr = nx;
                    n_pos = r_pos + 1'b1;
                end
            end
            S_RFIN: begin
                if (!r_found) begin
                    fin = 1'b1; fst = tmqt_pkg::ST_NO_MSG;
                end else if (32'(r_fsize) > 32'(r_len) && !r_ne) begin
                    fin = 1'b1; fst = tmqt_pkg::ST_TOO_BIG;
                end else if (r_cp) begin
                    fin = 1'b1; frecv = 1'b1;
                end else begin
                    n_state = S_RUNL;
                end
            end
            S_RUNL: begin
                x_we = (r_fpos != '0);
                x_waddr = r_fprev; x_wdata = r_fnext;
                up_recv = 1'b1;
                n_state = S_RFREE;
            end
            S_RFREE: begin
                x_we = 1'b1; x_waddr = r_f; x_wdata = r_fhead;
                n_fhead = r_f;
                n_fcnt = r_fcnt + 1'b1;
                fin = 1'b1; frecv = 1'b1;
            end
            // remove: return each descriptor to the free list
            S_MWALK: begin
                x_we = 1'b1; x_waddr = r_cur; x_wdata = r_fhead;
                n_fhead = r_cur;
                n_fcnt = r_fcnt + 1'b1;
                if (7'(r_pos + 1'b1) == r_scount[qi]) begin
                    n_state = S_MFIN;
                end else begin
                    n_cur = nx;
                    rd_addr = nx;
                    n_pos = r_pos + 1'b1;
                end
            end
            S_MFIN: begin
                up_clear = 1'b1;
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            n_state = S_IDLE;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fhead <= '0;
            r_fcnt  <= CW'(NP);
            r_done  <= 1'b0;
            r_nval  <= '0;
            r_use   <= '0;
        end else begin
            r_state <= n_state;
            r_fhead <= n_fhead;
            r_fcnt  <= n_fcnt;
            r_done  <= fin;
            if (x_we) begin
                r_nval[x_waddr] <= 1'b1;
            end
            if (up_create) begin
                r_use[ffree] <= 1'b1;
            end
            if (up_clear) begin
                r_use[qi] <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_q <= n_q; r_key <= n_key; r_type <= n_type; r_len <= n_len;
        r_ref <= n_ref; r_mode <= n_mode; r_cr <= n_cr; r_ex <= n_ex; r_ne <= n_ne;
        r_cp <= n_cp;
        r_i <= n_i; r_gidx <= n_gidx; r_gfound <= n_gfound;
        r_cur <= n_cur; r_prevw <= n_prevw; r_pos <= n_pos; r_found <= n_found;
        r_f <= n_f; r_fprev <= n_fprev; r_fpos <= n_fpos; r_fnext <= n_fnext;
        r_ftype <= n_ftype; r_fsize <= n_fsize; r_fref <= n_fref;
        r_nra <= rd_addr;
        r_nrv <= r_nval[rd_addr];
    end

    // slot table fields
    always_ff @(posedge i_clk) begin
        if (up_create) begin
            r_skey[ffree]   <= r_key;
            r_smode[ffree]  <= r_mode & tmqt_pkg::MODE_MASK;
            r_sbytes[ffree] <= '0;
            r_scount[ffree] <= '0;
            r_slimit[ffree] <= 15'(tmqt_pkg::DEFAULT_QUEUE_BYTES);
            r_shead[ffree]  <= '0;
            r_stail[ffree]  <= '0;
        end
        if (up_set) begin
            r_smode[qi] <= r_mode & tmqt_pkg::MODE_MASK;
            if (r_len != 16'd0 && r_len <= 16'(tmqt_pkg::DEFAULT_QUEUE_BYTES)) begin
                r_slimit[qi] <= r_len[14:0];
            end
        end
        if (up_push) begin
            if (r_scount[qi] == 7'd0) begin
                r_shead[qi] <= r_fhead;
            end
            r_stail[qi]  <= r_fhead;
            r_sbytes[qi] <= r_sbytes[qi] + 15'(r_len);
            r_scount[qi] <= r_scount[qi] + 7'd1;
        end
        if (up_recv) begin
            if (r_fpos == '0) begin
                r_shead[qi] <= r_fnext;
            end
            if (7'(r_fpos + 1'b1) == r_scount[qi]) begin
                r_stail[qi] <= r_fprev;
            end
            r_sbytes[qi] <= r_sbytes[qi] - 15'(r_fsize);
            r_scount[qi] <= r_scount[qi] - 7'd1;
        end
        if (up_clear) begin
            r_sbytes[qi] <= '0;
            r_scount[qi] <= '0;
        end
    end

    // result register, fields zero on error
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_status <= fst;
            r_qo     <= (fst == tmqt_pkg::ST_OK) ? fqo : '0;
            r_otype  <= (fst == tmqt_pkg::ST_OK && frecv) ? r_ftype : '0;
            r_olen   <= (fst == tmqt_pkg::ST_OK && frecv) ? dlv : '0;
            r_oref   <= (fst == tmqt_pkg::ST_OK && frecv) ? r_fref : '0;
            r_obytes <= (fst == tmqt_pkg::ST_OK && fstat) ? r_sbytes[qi] : '0;
            r_ocount <= (fst == tmqt_pkg::ST_OK && fstat) ? r_scount[qi] : '0;
            r_olimit <= (fst == tmqt_pkg::ST_OK && fstat) ? r_slimit[qi] : '0;
            r_omode  <= (fst == tmqt_pkg::ST_OK && fstat) ? r_smode[qi] : '0;
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_queue_id_out    = r_qo;
    assign o_msg_type_out    = r_otype;
    assign o_length_out      = r_olen;
    assign o_payload_ref_out = r_oref;
    assign o_queued_bytes    = r_obytes;
    assign o_queued_count    = r_ocount;
    assign o_byte_limit      = r_olimit;
    assign o_mode_out        = r_omode;
endmodule

/* hw/rtl/tmqt_ram.sv */
// generic single write port ram with registered read
module tmqt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sim/tb_typed_message_queue_table_core.sv */
// self-checking testbench for the typed message queue table core
module tb_typed_message_queue_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNKNOWN = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 100;
    localparam int NQ = tmqt_pkg::NUM_QUEUES;
    localparam int NP = tmqt_pkg::POOL_ENTRIES;
    localparam int MAXB = tmqt_pkg::MAX_MESSAGE_BYTES;
    localparam int DEFB = tmqt_pkg::DEFAULT_QUEUE_BYTES;

    typedef struct {
        logic [2:0]  op;
        logic [3:0]  qid;
        logic [31:0] key;
        logic [31:0] mtype;
        logic [15:0] len;
        logic [31:0] pref;
        logic [8:0]  mode;
        logic        cr;
        logic        ex;
        logic        noerr;
        logic        copy;
        int          idle_pct;
        bit          drain;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  qid;
        logic [30:0] mtype;
        logic [13:0] len;
        logic [31:0] pref;
        logic [14:0] bytes;
        logic [6:0]  count;
        logic [14:0] limit;
        logic [8:0]  mode;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_operation = '0;
    logic [3:0]  i_queue_id = '0;
    logic [31:0] i_key = '0;
    logic signed [31:0] i_msg_type = '0;
    logic [15:0] i_length = '0;
    logic [31:0] i_payload_ref = '0;
    logic [8:0]  i_mode_bits = '0;
    logic        i_create_flag = 1'b0;
    logic        i_exclusive_flag = 1'b0;
    logic        i_no_error_flag = 1'b0;
    logic        i_copy_flag = 1'b0;
    logic        o_busy, o_done;
    logic [3:0]  o_status, o_queue_id_out;
    logic [30:0] o_msg_type_out;
    logic [13:0] o_length_out;
    logic [31:0] o_payload_ref_out;
    logic [14:0] o_queued_bytes, o_byte_limit;
    logic [6:0]  o_queued_count;
    logic [8:0]  o_mode_out;

    typed_message_queue_table_core dut (.*);

    always #10 i_clk = ~i_clk;

    // table and pool shadow state
    bit          q_used [NQ];
    logic [31:0] q_key [NQ];
    logic [8:0]  q_mode [NQ];
    int          q_bytes [NQ];
    int          q_count [NQ];
    int          q_limit [NQ];
    int          q_head [NQ];
    int          q_tail [NQ];
    logic [30:0] d_type [NP];
    int          d_size [NP];
    logic [31:0] d_ref [NP];
    int          d_next [NP];
    int          pool_head, pool_free;

    t_cmd    pending_items[$];
    t_result expected_results[$];
    int      error_count = 0;
    int      cycle_count = 0;

    function automatic void clear_table();
        for (int i = 0; i < NQ; i++) q_used[i] = 0;
        for (int i = 0; i < NP; i++) d_next[i] = (i + 1) % NP;
        pool_head = 0;
        pool_free = NP;
    endfunction

    function automatic void free_descriptor(int e);
        d_next[e] = pool_head;
        pool_head = e;
        pool_free++;
    endfunction

    // compute the answer of one command and update the shadow state
    function automatic t_result apply_command(t_cmd c);
        t_result r;
        tmqt_pkg::t_status st;
        int hit, slot, e, cur, prev, f, fprev, fpos, n, sz;
        bit found, stop;
        longint sel, mag;
        r = '0;
        st = tmqt_pkg::ST_INVALID;
        hit = -1;
        slot = -1;
        case (c.op)
            tmqt_pkg::OP_GET: begin
                if (c.key != 0)
                    for (int i = 0; i < NQ; i++)
                        if (hit < 0 && q_used[i] && q_key[i] == c.key) hit = i;
                if (hit >= 0) begin
                    st = (c.cr && c.ex) ? tmqt_pkg::ST_EXISTS : tmqt_pkg::ST_OK;
                    r.qid = 4'(hit);
                end else if (c.key != 0 && !c.cr) begin
                    st = tmqt_pkg::ST_NOT_FOUND;
                end else begin
                    for (int i = 0; i < NQ; i++)
                        if (slot < 0 && !q_used[i]) slot = i;
                    if (slot < 0) begin
                        st = tmqt_pkg::ST_NO_SPACE;
                    end else begin
                        q_used[slot] = 1;
                        q_key[slot] = c.key;
                        q_mode[slot] = c.mode & tmqt_pkg::MODE_MASK;
                        q_bytes[slot] = 0;
                        q_count[slot] = 0;
                        q_limit[slot] = DEFB;
                        q_head[slot] = 0;
                        q_tail[slot] = 0;
                        r.qid = 4'(slot);
                        st = tmqt_pkg::ST_OK;
                    end
                end
            end
            tmqt_pkg::OP_SEND: begin
                if (!q_used[c.qid] || int'(c.len) > MAXB || $signed(c.mtype) <= 0)
                    st = tmqt_pkg::ST_INVALID;
                else if (q_bytes[c.qid] + int'(c.len) > q_limit[c.qid])
                    st = tmqt_pkg::ST_FULL;
                else if (pool_free == 0)
                    st = tmqt_pkg::ST_POOL;
                else begin
                    e = pool_head;
                    pool_head = d_next[e];
                    pool_free--;
                    d_type[e] = c.mtype[30:0];
                    d_size[e] = int'(c.len);
                    d_ref[e] = c.pref;
                    d_next[e] = 0;
                    if (q_count[c.qid] == 0) q_head[c.qid] = e;
                    else d_next[q_tail[c.qid]] = e;
                    q_tail[c.qid] = e;
                    q_bytes[c.qid] += int'(c.len);
                    q_count[c.qid]++;
                    st = tmqt_pkg::ST_OK;
                end
            end
            tmqt_pkg::OP_RECEIVE: begin
                if (q_used[c.qid]) begin
                    sel = longint'($signed(c.mtype));
                    mag = -sel;
                    n = q_count[c.qid];
                    cur = q_head[c.qid];
                    prev = 0;
                    f = 0; fprev = 0; fpos = 0;
                    found = 0; stop = 0;
                    // walk the chain: exact or head match stops, negative keeps the lowest
                    for (int pos = 0; pos < n && !stop; pos++) begin
                        if (sel == 0 || (sel > 0 && longint'(d_type[cur]) == sel)) begin
                            f = cur; fprev = prev; fpos = pos; found = 1; stop = 1;
                        end else begin
                            if (sel < 0 && longint'(d_type[cur]) <= mag &&
                                (!found || d_type[cur] < d_type[f])) begin
                                f = cur; fprev = prev; fpos = pos; found = 1;
                            end
                            prev = cur;
                            cur = d_next[cur];
                        end
                    end
                    sz = found ? d_size[f] : 0;
                    if (!found) st = tmqt_pkg::ST_NO_MSG;
                    else if (sz > int'(c.len) && !c.noerr) st = tmqt_pkg::ST_TOO_BIG;
                    else begin
                        if (sz > int'(c.len)) sz = int'(c.len);
                        st = tmqt_pkg::ST_OK;
                        r.mtype = d_type[f];
                        r.len = 14'(sz);
                        r.pref = d_ref[f];
                        if (!c.copy) begin
                            if (fpos == 0) q_head[c.qid] = d_next[f];
                            else d_next[fprev] = d_next[f];
                            if (fpos + 1 == n) q_tail[c.qid] = fprev;
                            q_bytes[c.qid] -= d_size[f];
                            q_count[c.qid]--;
                            free_descriptor(f);
                        end
                    end
                end
            end
            tmqt_pkg::OP_REMOVE: begin
                if (q_used[c.qid]) begin
                    cur = q_head[c.qid];
                    for (int k = 0; k < q_count[c.qid]; k++) begin
                        e = d_next[cur];
                        free_descriptor(cur);
                        cur = e;
                    end
                    q_used[c.qid] = 0;
                    q_count[c.qid] = 0;
                    q_bytes[c.qid] = 0;
                    st = tmqt_pkg::ST_OK;
                end
            end
            tmqt_pkg::OP_STAT: begin
                if (q_used[c.qid]) begin
                    st = tmqt_pkg::ST_OK;
                    r.bytes = 15'(q_bytes[c.qid]);
                    r.count = 7'(q_count[c.qid]);
                    r.limit = 15'(q_limit[c.qid]);
                    r.mode = q_mode[c.qid];
                end
            end
            tmqt_pkg::OP_SET: begin
                if (q_used[c.qid]) begin
                    st = tmqt_pkg::ST_OK;
                    q_mode[c.qid] = c.mode & tmqt_pkg::MODE_MASK;
                    if (c.len > 0 && int'(c.len) <= DEFB) q_limit[c.qid] = int'(c.len);
                end
            end
            tmqt_pkg::OP_INFO: begin
                st = tmqt_pkg::ST_OK;
                r.qid = 4'(NQ - 1);
            end
            default: st = tmqt_pkg::ST_INVALID;
        endcase
        if (st != tmqt_pkg::ST_OK) r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic t_cmd make_cmd(logic [2:0] op, logic [3:0] qid, logic [31:0] key,
                                      logic [31:0] mtype, logic [15:0] len, int idle);
        t_cmd c;
        c.op = op; c.qid = qid; c.key = key; c.mtype = mtype; c.len = len;
        c.pref = $urandom; c.mode = 9'($urandom_range(0, 511));
        c.cr = 0; c.ex = 0; c.noerr = 0; c.copy = 0;
        c.idle_pct = idle; c.drain = 0;
        return c;
    endfunction

    // random command biased toward a few live queues and small types
    function automatic t_cmd random_cmd(int idle);
        t_cmd c;
        int pick, w;
        logic [31:0] keys [6];
        keys = '{32'd1, 32'd2, 32'd3, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0};
        c = make_cmd(tmqt_pkg::OP_INFO, 0, 0, 0, 0, idle);
        c.cr = 1'($urandom_range(0, 1)); c.ex = 1'($urandom_range(0, 1));
        c.noerr = 1'($urandom_range(0, 1)); c.copy = $urandom_range(0, 3) == 0;
        c.qid = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 5)) :
                                             4'($urandom_range(0, 15));
        c.key = ($urandom_range(0, 4) == 0) ? $urandom : keys[$urandom_range(0, 5)];
        pick = $urandom_range(0, 99);
        if (pick < 12) c.op = tmqt_pkg::OP_GET;
        else if (pick < 50) c.op = tmqt_pkg::OP_SEND;
        else if (pick < 78) c.op = tmqt_pkg::OP_RECEIVE;
        else if (pick < 82) c.op = tmqt_pkg::OP_REMOVE;
        else if (pick < 90) c.op = tmqt_pkg::OP_STAT;
        else if (pick < 95) c.op = tmqt_pkg::OP_SET;
        else if (pick < 98) c.op = tmqt_pkg::OP_INFO;
        else c.op = OP_UNKNOWN;
        w = $urandom_range(0, 19);
        if (c.op == tmqt_pkg::OP_SEND)
            c.mtype = (w < 16) ? $urandom_range(1, 6) : (w < 18) ? $urandom : 32'h7FFF_FFFF;
        else if (w < 4) c.mtype = 0;
        else if (w < 10) c.mtype = $urandom_range(1, 6);
        else if (w < 16) c.mtype = -$urandom_range(1, 6);
        else if (w < 17) c.mtype = 32'h8000_0000;
        else c.mtype = $urandom;
        w = $urandom_range(0, 19);
        if (c.op == tmqt_pkg::OP_SET)
            c.len = (w < 4) ? 16'd0 : (w < 12) ? 16'($urandom_range(1, 2000)) :
                    (w < 15) ? 16'(DEFB) : 16'($urandom);
        else
            c.len = (w < 14) ? 16'($urandom_range(0, 300)) :
                    (w < 18) ? 16'($urandom_range(0, MAXB)) : 16'($urandom);
        return c;
    endfunction

    // driver: presents pending items and records predictions on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            if (i_start)
                expected_results.push_back(apply_command(pending_items.pop_front()));
            if (pending_items.size() == 0) begin
                i_start <= 1'b0;
            end else if (pending_items[0].drain && (i_start || expected_results.size() != 0)) begin
                i_start <= 1'b0;
            end else if ($urandom_range(0, 99) < pending_items[0].idle_pct) begin
                i_start <= 1'b0;
            end else begin
                pending_items[0].drain = 0;
                i_start          <= 1'b1;
                i_operation      <= pending_items[0].op;
                i_queue_id       <= pending_items[0].qid;
                i_key            <= pending_items[0].key;
                i_msg_type       <= pending_items[0].mtype;
                i_length         <= pending_items[0].len;
                i_payload_ref    <= pending_items[0].pref;
                i_mode_bits      <= pending_items[0].mode;
                i_create_flag    <= pending_items[0].cr;
                i_exclusive_flag <= pending_items[0].ex;
                i_no_error_flag  <= pending_items[0].noerr;
                i_copy_flag      <= pending_items[0].copy;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // monitor: compares every result strobe with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: status %0h", $time, o_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("queue_id_out", 32'(want.qid), 32'(o_queue_id_out));
                check_field("msg_type_out", 32'(want.mtype), 32'(o_msg_type_out));
                check_field("length_out", 32'(want.len), 32'(o_length_out));
                check_field("payload_ref_out", want.pref, o_payload_ref_out);
                check_field("queued_bytes", 32'(want.bytes), 32'(o_queued_bytes));
                check_field("queued_count", 32'(want.count), 32'(o_queued_count));
                check_field("byte_limit", 32'(want.limit), 32'(o_byte_limit));
                check_field("mode_out", 32'(want.mode), 32'(o_mode_out));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        int idle;
        clear_table();

        // directed: empty table, bad codes, get flags, typed receive, limits
        pending_items.push_back(make_cmd(tmqt_pkg::OP_INFO, 4'hF, 0, 0, 0, 0));
        pending_items.push_back(make_cmd(OP_UNKNOWN, 0, 0, 0, 0, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_STAT, 4'hF, 0, 0, 0, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_GET, 0, 0, 0, 0, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_GET, 0, 32'hFFFF_FFFF, 0, 0, 0));
        c = make_cmd(tmqt_pkg::OP_GET, 0, 32'hFFFF_FFFF, 0, 0, 0); c.cr = 1; c.mode = 9'h1FF;
        pending_items.push_back(c);
        c.ex = 1; pending_items.push_back(c);
        c.cr = 0; pending_items.push_back(c);
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SEND, 1, 0, 0, 10, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SEND, 1, 0, 32'h8000_0000, 10, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SEND, 1, 0, 5, 16'(MAXB + 1), 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SEND, 1, 0, 32'h7FFF_FFFF, 16'(MAXB), 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SEND, 1, 0, 3, 0, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SEND, 1, 0, 2, 100, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_RECEIVE, 1, 0, 9, 100, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_RECEIVE, 1, 0, -3, 100, 0));
        c = make_cmd(tmqt_pkg::OP_RECEIVE, 1, 0, 32'h8000_0000, 16'hFFFF, 0); c.copy = 1;
        pending_items.push_back(c);
        pending_items.push_back(make_cmd(tmqt_pkg::OP_RECEIVE, 1, 0, 32'h7FFF_FFFF, 50, 0));
        c = make_cmd(tmqt_pkg::OP_RECEIVE, 1, 0, 32'h7FFF_FFFF, 50, 0); c.noerr = 1;
        pending_items.push_back(c);
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SET, 1, 0, 0, 0, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SET, 1, 0, 0, 16'(DEFB + 1), 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SET, 1, 0, 0, 150, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_SEND, 1, 0, 1, 200, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_STAT, 1, 0, 0, 0, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_REMOVE, 1, 0, 0, 0, 0));
        pending_items.push_back(make_cmd(tmqt_pkg::OP_REMOVE, 1, 0, 0, 0, 0));

        // random phases with varying sender idling
        for (int n = 0; n < 1250; n++) begin
            case (n / 250)
                0: idle = 0;
                1: idle = 67;
                2: idle = 11;
                3: idle = ((n / 25) % 2) ? 67 : 0;
                default: idle = $urandom_range(0, 1) ? 11 : 0;
            endcase
            c = random_cmd(idle);
            if (n % 300 == 150) c.drain = 1;
            pending_items.push_back(c);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/tmqt_pkg.sv
hw/rtl/tmqt_ram.sv
hw/rtl/typed_message_queue_table_core.sv
sim/tb_typed_message_queue_table_core.sv
